/* rtl/deadline_timer_queue_top_macros.svh */
// Assertion macros shared by the checker.
`ifndef DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DTQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;
    localparam int TIMER_SLOTS_DEF = 16;
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [47:0] DL_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] now;
        logic [47:0] deadline;
        logic [31:0] period;
        logic [15:0] cancel_id;
        logic        handler_stop;
    } in_item_t;

    typedef struct packed {
        logic [15:0] assigned_id;
        logic        table_full;
        logic        fired;
        logic [15:0] fired_id;
        logic        has_next;
        logic [47:0] next_deadline;
        logic [31:0] next_period;
    } out_item_t;

    // Candidate that travels down the cell chain during a scan.
    typedef struct packed {
        logic        valid;
        logic [47:0] deadline;
        logic [15:0] age;
        logic [31:0] period;
        logic [15:0] ident;
    } cand_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic        clear_id;   // free every valid slot holding ident
        logic        fire;       // act on the slot that won the scan
        logic        rearm;      // fire re-arms instead of freeing
        logic        load;       // write the new timer into the free slot
        logic [15:0] ident;
        logic [47:0] deadline;
        logic [31:0] period;
        logic [15:0] stamp;
        logic [15:0] counter;
    } cell_cmd_t;
endpackage

/* rtl/dtq_cell.sv */
// ----------------------------------------------------------------------------
// dtq_cell
// One timer slot. Compares its timer with the candidate from its upstream
// neighbor and registers the better one for the next cell.
// ----------------------------------------------------------------------------
module dtq_cell #(
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dtq_pkg::cand_t    cand_in,
    input  logic [IDX_W-1:0]  win_in,
    input  logic [IDX_W-1:0]  my_idx,
    input  dtq_pkg::cell_cmd_t cmd,
    input  logic              is_free_pick, // this slot takes the new timer
    input  logic              is_win,       // this slot won the last scan
    output dtq_pkg::cand_t    cand_out,
    output logic [IDX_W-1:0]  win_out,
    output logic              slot_used
);
    logic        valid_reg;
    logic [15:0] ident_reg;
    logic [47:0] dl_reg;
    logic [31:0] per_reg;
    logic [15:0] stamp_reg;
    logic [15:0] age;
    logic        better;
    dtq_pkg::cand_t cand_next;
    logic [IDX_W-1:0] win_next;

    assign age = cmd.counter - stamp_reg;
    // Ties keep the upstream (lower slot) candidate unless this one is older.
    assign better = valid_reg && (!cand_in.valid || dl_reg < cand_in.deadline ||
                    (dl_reg == cand_in.deadline && age > cand_in.age));

    always_comb
    begin
        cand_next = cand_in;
        win_next  = win_in;
        if (better)
        begin
            cand_next.valid    = 1'b1;
            cand_next.deadline = dl_reg;
            cand_next.age      = age;
            cand_next.period   = per_reg;
            cand_next.ident    = ident_reg;
            win_next           = my_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.clear_id && valid_reg && ident_reg == cmd.ident)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.fire && is_win && !cmd.rearm)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.load && is_free_pick)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && is_free_pick)
        begin
            ident_reg <= cmd.ident;
            dl_reg    <= cmd.deadline;
            per_reg   <= cmd.period;
            stamp_reg <= cmd.stamp;
        end
        else if (cmd.fire && is_win && cmd.rearm)
        begin
            dl_reg    <= cmd.deadline;
            stamp_reg <= cmd.stamp;
        end
        cand_out <= cand_next;
        win_out  <= win_next;
    end

    assign slot_used = valid_reg;
endmodule

/* rtl/deadline_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Pending timer table built as a chain of slot cells with a scan controller.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / ready | dtq_pkg::in_item_t
// out     | output    | valid / ready | dtq_pkg::out_item_t
//
// After the input transaction the result passes through these states: a scan
// down the cell chain (SCAN1) finds the earliest timer before the command,
// EXEC executes it, a second scan (SCAN2) reports the earliest timer after it,
// and DONE hands the result on to the output register. A new transaction is
// taken only once the previous result has left DONE. Reset clears all slots
// at once. A result waits in its own output register, so the next transaction
// may run meanwhile; its result then waits until the output register is free.
module deadline_timer_queue_top #(
    parameter int TIMER_SLOTS = dtq_pkg::TIMER_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dtq_pkg::out_item_t out_data
);
    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIMER_SLOTS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN1 = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SCAN2 = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    dtq_pkg::in_item_t item_reg;
    logic [15:0]      last_id_reg, counter_reg;
    dtq_pkg::out_item_t res_reg;
    dtq_pkg::out_item_t out_data_reg;
    logic             out_valid_reg;
    logic             out_load;
    dtq_pkg::cell_cmd_t cmd;

    dtq_pkg::cand_t   cand [TIMER_SLOTS+1];
    logic [IDX_W-1:0] win  [TIMER_SLOTS+1];
    logic [TIMER_SLOTS-1:0] used;
    logic [TIMER_SLOTS-1:0] free_pick;
    logic [IDX_W-1:0] win_reg;
    dtq_pkg::cand_t   best_reg;
    logic             due, any_free;
    logic [48:0]      sum;

    // Feed the chain head with an empty candidate; result appears at the tail.
    assign cand[0] = '0;
    assign win[0]  = '0;

    // Lowest free slot as a priority one-hot.
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            free_pick[i] = ~used[i] & ~seen;
            seen = seen | ~used[i];
        end
    end
    assign any_free = ~&used;

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_cell
            dtq_cell #(.IDX_W(IDX_W)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .cand_in(cand[g]), .win_in(win[g]),
                .my_idx(IDX_W'(g)), .cmd(cmd),
                .is_free_pick(free_pick[g]),
                .is_win(win_reg == IDX_W'(g)),
                .cand_out(cand[g+1]), .win_out(win[g+1]),
                .slot_used(used[g])
            );
        end
    endgenerate

    assign due = best_reg.valid && (item_reg.now >= best_reg.deadline);
    assign sum = {1'b0, item_reg.now} + {17'd0, best_reg.period};

    always_comb
    begin
        cmd = '0;
        cmd.counter = counter_reg;
        cmd.stamp   = counter_reg + 16'd1;
        cmd.ident   = item_reg.cancel_id;
        if (state_reg == ST_EXEC)
        begin
            unique case (item_reg.action)
                dtq_pkg::ACT_ADD:
                begin
                    cmd.load     = any_free;
                    cmd.ident    = last_id_reg + 16'd1;
                    cmd.deadline = item_reg.deadline;
                    cmd.period   = item_reg.period;
                end
                dtq_pkg::ACT_REMOVE: cmd.clear_id = 1'b1;
                dtq_pkg::ACT_TICK:
                begin
                    cmd.fire     = due;
                    cmd.rearm    = (best_reg.period != 32'd0) && !item_reg.handler_stop;
                    cmd.deadline = sum[48] ? dtq_pkg::DL_MAX : sum[47:0];
                end
                default: ;
            endcase
        end
    end

    // The finished result moves to the output register once that is free.
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid && in_ready) state_next = ST_SCAN1;
            end
            ST_SCAN1: if (cnt_reg == CNT_LAST) state_next = ST_EXEC;
            ST_EXEC:
            begin
                cnt_next   = '0;
                state_next = ST_SCAN2;
            end
            ST_SCAN2: if (cnt_reg == CNT_LAST) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_id_reg   <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cmd.load || (cmd.fire && cmd.rearm))
                counter_reg <= counter_reg + 16'd1;
            if (cmd.load)
                last_id_reg <= last_id_reg + 16'd1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (state_reg == ST_SCAN1 && cnt_reg == CNT_LAST)
        begin
            best_reg <= cand[TIMER_SLOTS];
            win_reg  <= win[TIMER_SLOTS];
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg.assigned_id <= (item_reg.action == dtq_pkg::ACT_ADD && any_free) ?
                                   last_id_reg + 16'd1 : 16'd0;
            res_reg.table_full  <= (item_reg.action == dtq_pkg::ACT_ADD) && !any_free;
            res_reg.fired       <= cmd.fire;
            res_reg.fired_id    <= cmd.fire ? best_reg.ident : 16'd0;
        end
        if (state_reg == ST_SCAN2 && cnt_reg == CNT_LAST)
        begin
            res_reg.has_next      <= cand[TIMER_SLOTS].valid;
            res_reg.next_deadline <= cand[TIMER_SLOTS].valid ?
                                     cand[TIMER_SLOTS].deadline : 48'd0;
            res_reg.next_period   <= cand[TIMER_SLOTS].valid ?
                                     cand[TIMER_SLOTS].period : 32'd0;
        end
        if (out_load)
            out_data_reg <= res_reg;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

/* rtl/dtq_checker.sv */
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the deadline timer queue.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_top_macros.svh"
module dtq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dtq_pkg::out_item_t out_data
);
    `DTQ_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid)
    `DTQ_ASSERT_NEXT(a_data_hold, out_valid && !out_ready, $stable(out_data))
    `DTQ_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
    `DTQ_ASSERT_IMPL(a_full_noid, out_valid && out_data.table_full, out_data.assigned_id == 16'd0)
    `DTQ_ASSERT_IMPL(a_fire_excl, out_valid && out_data.fired, !out_data.table_full)
endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add, remove and tick transactions into the deadline timer queue and
// checks every result against a known table row or a cycle-free model of the timer table.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int SLOTS = dtq_pkg::TIMER_SLOTS_DEF;
    localparam int N_RANDOM = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] ACT_NOP = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    dtq_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    dtq_pkg::out_item_t out_data;

    always #10 clk = ~clk;

    deadline_timer_queue_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Timer table mirror.
    logic        tm_valid [SLOTS];
    logic [15:0] tm_ident [SLOTS];
    logic [47:0] tm_deadline [SLOTS];
    logic [31:0] tm_period [SLOTS];
    logic [15:0] tm_stamp [SLOTS];
    logic [15:0] tm_last_ident;
    logic [15:0] tm_counter;

    dtq_pkg::out_item_t pending_results[$];
    int errors = 0;
    int n_checked = 0;
    int n_fired = 0;
    int n_full = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_off = 0;

    function automatic int earliest_timer();
        int best;
        best = -1;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!tm_valid[s])
                continue;
            if (best < 0 || tm_deadline[s] < tm_deadline[best] ||
                (tm_deadline[s] == tm_deadline[best] &&
                 16'(tm_counter - tm_stamp[s]) > 16'(tm_counter - tm_stamp[best])))
                best = s;
        end
        return best;
    endfunction

    function automatic dtq_pkg::out_item_t apply_timer_cmd(dtq_pkg::in_item_t it);
        dtq_pkg::out_item_t r;
        int e;
        int fs;
        logic [48:0] nd;
        r = '0;
        unique case (it.action)
            dtq_pkg::ACT_ADD:
            begin
                fs = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (!tm_valid[s] && fs < 0)
                        fs = s;
                if (fs < 0)
                    r.table_full = 1'b1;
                else
                begin
                    tm_last_ident = tm_last_ident + 16'd1;
                    tm_valid[fs] = 1'b1;
                    tm_ident[fs] = tm_last_ident;
                    tm_deadline[fs] = it.deadline;
                    tm_period[fs] = it.period;
                    tm_counter = tm_counter + 16'd1;
                    tm_stamp[fs] = tm_counter;
                    r.assigned_id = tm_last_ident;
                end
            end
            dtq_pkg::ACT_REMOVE:
                for (int s = 0; s < SLOTS; s++)
                    if (tm_valid[s] && tm_ident[s] == it.cancel_id)
                        tm_valid[s] = 1'b0;
            dtq_pkg::ACT_TICK:
            begin
                e = earliest_timer();
                if (e >= 0 && it.now >= tm_deadline[e])
                begin
                    r.fired = 1'b1;
                    r.fired_id = tm_ident[e];
                    if (tm_period[e] == 32'd0 || it.handler_stop)
                        tm_valid[e] = 1'b0;
                    else
                    begin
                        nd = {1'b0, it.now} + {17'd0, tm_period[e]};
                        tm_deadline[e] = nd[48] ? dtq_pkg::DL_MAX : nd[47:0];
                        tm_counter = tm_counter + 16'd1;
                        tm_stamp[e] = tm_counter;
                    end
                end
            end
            default:
            begin
            end
        endcase
        e = earliest_timer();
        if (e >= 0)
        begin
            r.has_next = 1'b1;
            r.next_deadline = tm_deadline[e];
            r.next_period = tm_period[e];
        end
        return r;
    endfunction

    // Directed table: each row is a transaction and, when known, its result.
    typedef struct {
        dtq_pkg::in_item_t  cmd;
        bit                 known;
        dtq_pkg::out_item_t result;
    } row_t;
    row_t directed[$];

    function automatic dtq_pkg::in_item_t mk(logic [1:0] a, logic [47:0] now_v,
                                             logic [47:0] dl, logic [31:0] per,
                                             logic [15:0] id, logic stop);
        dtq_pkg::in_item_t it;
        it.action = a;
        it.now = now_v;
        it.deadline = dl;
        it.period = per;
        it.cancel_id = id;
        it.handler_stop = stop;
        return it;
    endfunction

    function automatic void add_row(dtq_pkg::in_item_t it, bit known,
                                    dtq_pkg::out_item_t res);
        row_t r;
        r.cmd = it;
        r.known = known;
        r.result = res;
        directed.push_back(r);
    endfunction

    // Valid stays high from one transaction to the next unless an idle burst
    // drops it.
    task automatic send_cmd(dtq_pkg::in_item_t it, bit known, dtq_pkg::out_item_t res);
        dtq_pkg::out_item_t want;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        want = apply_timer_cmd(it);
        if (known && want != res)
            $display("table row disagrees with prediction for action %0d", it.action);
        pending_results.push_back(known ? res : want);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        dtq_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_checked++;
            if (out_data.fired)
                n_fired++;
            if (out_data.table_full)
                n_full++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data != want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected id %h full %b fired %b fid %h %s",
                                 want.assigned_id, want.table_full, want.fired,
                                 want.fired_id, "");
                        $display("  next %b dl %h per %h", want.has_next,
                                 want.next_deadline, want.next_period);
                        $display("  actual id %h full %b fired %b fid %h",
                                 out_data.assigned_id, out_data.table_full,
                                 out_data.fired, out_data.fired_id);
                        $display("  next %b dl %h per %h", out_data.has_next,
                                 out_data.next_deadline, out_data.next_period);
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end.
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("[deadline_timer_queue_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        dtq_pkg::out_item_t none;
        dtq_pkg::out_item_t r;
        dtq_pkg::in_item_t it;
        logic [47:0] base;
        int kind;
        int wait_cycles;
        none = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            tm_valid[s] = 1'b0;
            tm_ident[s] = '0;
            tm_deadline[s] = '0;
            tm_period[s] = '0;
            tm_stamp[s] = '0;
        end
        tm_last_ident = '0;
        tm_counter = '0;

        // Empty table: tick, remove and no-op report nothing pending.
        add_row(mk(dtq_pkg::ACT_TICK, dtq_pkg::DL_MAX, '0, '0, '0, 1'b1), 1, none);
        add_row(mk(dtq_pkg::ACT_REMOVE, '0, '0, '0, 16'hFFFF, 1'b0), 1, none);
        add_row(mk(ACT_NOP, dtq_pkg::DL_MAX, dtq_pkg::DL_MAX, '1, '1, 1'b1), 1, none);
        r = none;
        r.assigned_id = 16'd1;
        r.has_next = 1'b1;
        r.next_deadline = dtq_pkg::DL_MAX;
        r.next_period = 32'hFFFF_FFFF;
        add_row(mk(dtq_pkg::ACT_ADD, '0, dtq_pkg::DL_MAX, 32'hFFFF_FFFF, '0, 1'b0), 1, r);
        // Equal deadlines: earlier insertion fires first; saturating re-arm.
        add_row(mk(dtq_pkg::ACT_ADD, '0, 48'd100, 32'd0, '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_ADD, '0, 48'd100, 32'd50, '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_TICK, 48'd99, '0, '0, '0, 1'b1), 0, none);
        add_row(mk(dtq_pkg::ACT_TICK, 48'd100, '0, '0, '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_TICK, 48'd200, '0, '0, '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_TICK, 48'd250, '0, '0, '0, 1'b1), 0, none);
        add_row(mk(dtq_pkg::ACT_ADD, '0, 48'd0, 32'hFFFF_FFFF, '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_TICK, dtq_pkg::DL_MAX - 48'd5, '0, '0, '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_REMOVE, '0, '0, '0, 16'd1, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_REMOVE, '0, '0, '0, 16'd6, 1'b0), 0, none);
        // Fill the table, then add past it: the last two adds find it full.
        for (int k = 0; k < SLOTS; k++)
            add_row(mk(dtq_pkg::ACT_ADD, '0, 48'(k * 7), 32'(k), '0, 1'b0), 0, none);
        add_row(mk(dtq_pkg::ACT_ADD, '0, 48'd1, 32'd1, '0, 1'b0), 0, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_cmd(directed[i].cmd, directed[i].known, directed[i].result);

        // Random part: time moves forward mostly, with occasional jumps.
        base = 48'd1000;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_off = 1;
            if (n == N_RANDOM - 200)
                quiet = 1;
            base = base + 48'($urandom_range(0, 40));
            it = mk(dtq_pkg::ACT_TICK, base, '0, '0, '0, 1'($urandom_range(0, 1)));
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                it.action = dtq_pkg::ACT_ADD;
                it.deadline = base + 48'($urandom_range(0, 200));
                it.period = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 120));
                if ($urandom_range(0, 19) == 0)
                begin
                    it.deadline = 48'({$urandom, $urandom});
                    it.period = $urandom;
                end
            end
            else if (kind < 50)
            begin
                it.action = dtq_pkg::ACT_REMOVE;
                it.cancel_id = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                               : tm_last_ident - 16'($urandom_range(0, 20));
            end
            else if (kind < 97)
            begin
                if ($urandom_range(0, 29) == 0)
                    base = 48'({$urandom, $urandom});
                it.now = base;
            end
            else
                it = mk(ACT_NOP, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        $urandom, 16'($urandom), 1'($urandom));
            // Random content in unused fields too.
            if ($urandom_range(0, 9) == 0)
                it.cancel_id = 16'($urandom);
            send_cmd(it, 0, none);
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        $display("checked %0d results: %0d timers fired, %0d adds hit a full table",
                 n_checked, n_fired, n_full);
        if (errors == 0 && pending_results.size() == 0)
            $display("[deadline_timer_queue_top] OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("[deadline_timer_queue_top] ERROR");
        end
        $finish;
    end
endmodule
